### rtl/tcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_pkg
// Shared types and constants of the constant-padding stream unit.
// ----------------------------------------------------------------------------
package tcp_pkg;

  // Default geometry
  localparam int DEF_MAX_AXES  = 4;
  localparam int DEF_SIZE_BITS = 12;

  // Element word and configuration index widths
  localparam int WORD_W    = 32;
  localparam int CFG_IDX_W = 8;

  // Result queue depth
  localparam int QUEUE_DEPTH = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IN_SIZES   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PAD_BEFORE = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_PAD_AFTER  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_PAD_WORD   = CFG_IDX_W'(3);

  // One result word as it travels from the front to the output queue
  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic              valid;
    logic              took;
    logic              last;
  } tcp_res_t;

endpackage

### rtl/tcp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_front
// Holds the configuration and the per-axis output counters, classifies each
// accepted tick (inside, border or hold) and builds its result word.
// ----------------------------------------------------------------------------
module tcp_front #(
  parameter int MAX_AXES  = tcp_pkg::DEF_MAX_AXES,
  parameter int SIZE_BITS = tcp_pkg::DEF_SIZE_BITS,
  parameter int CFG_W     = (MAX_AXES * SIZE_BITS > tcp_pkg::WORD_W) ?
                            MAX_AXES * SIZE_BITS : tcp_pkg::WORD_W
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write
  input  logic                           cfg_we,
  input  logic [tcp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]               cfg_data,
  // accepted input word
  input  logic                           in_fire,
  input  logic [tcp_pkg::WORD_W-1:0]     head_value,
  input  logic                           head_present,
  // result word toward the queue
  output tcp_pkg::tcp_res_t              res
);
  import tcp_pkg::*;

  localparam int REG_W = MAX_AXES * SIZE_BITS;
  localparam int POS_W = SIZE_BITS + 2;

  logic [REG_W-1:0]  in_sizes_r;
  logic [REG_W-1:0]  pad_before_r;
  logic [REG_W-1:0]  pad_after_r;
  logic [WORD_W-1:0] pad_word_r;

  logic [MAX_AXES-1:0][POS_W-1:0] pos_r, pos_nxt;
  logic [MAX_AXES-1:0]            at_end;
  logic                           in_region;
  logic                           last;
  logic                           emit;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < MAX_AXES; a++) begin
        in_sizes_r[a*SIZE_BITS +: SIZE_BITS] <= SIZE_BITS'(1);
      end
      pad_before_r <= '0;
      pad_after_r  <= '0;
      pad_word_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IN_SIZES:   in_sizes_r   <= cfg_data[REG_W-1:0];
        REG_PAD_BEFORE: pad_before_r <= cfg_data[REG_W-1:0];
        REG_PAD_AFTER:  pad_after_r  <= cfg_data[REG_W-1:0];
        REG_PAD_WORD:   pad_word_r   <= cfg_data[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  // Per-axis classification; axis 0 sits in the top field
  always_comb begin
    logic [SIZE_BITS-1:0] sz, bf, af;
    logic [POS_W-1:0]     osz, p1, hi;
    int                   sh;
    in_region = 1'b1;
    last      = 1'b1;
    for (int a = 0; a < MAX_AXES; a++) begin
      sh  = (MAX_AXES - 1 - a) * SIZE_BITS;
      sz  = in_sizes_r[sh +: SIZE_BITS];
      bf  = pad_before_r[sh +: SIZE_BITS];
      af  = pad_after_r[sh +: SIZE_BITS];
      osz = POS_W'(sz) + POS_W'(bf) + POS_W'(af);
      hi  = POS_W'(bf) + POS_W'(sz);
      p1  = pos_r[a] + POS_W'(1);
      if (pos_r[a] < POS_W'(bf) || pos_r[a] >= hi) begin
        in_region = 1'b0;
      end
      // an empty output axis acts as size one
      at_end[a] = ({1'b0, p1} >= {1'b0, osz});
      if (!at_end[a]) begin
        last = 1'b0;
      end
    end
  end

  // Inside the region with no head word: the result is marked not emitted, position holds
  assign emit = !(in_region && !head_present);

  always_comb begin
    res.value = '0;
    res.valid = 1'b0;
    res.took  = 1'b0;
    res.last  = 1'b0;
    if (emit) begin
      res.value = in_region ? head_value : pad_word_r;
      res.valid = 1'b1;
      res.took  = in_region;
      res.last  = last;
    end
  end

  // Odometer advance, last axis fastest
  always_comb begin
    logic carry;
    carry   = 1'b1;
    pos_nxt = pos_r;
    for (int k = MAX_AXES - 1; k >= 0; k--) begin
      if (carry) begin
        if (at_end[k]) begin
          pos_nxt[k] = '0;
        end else begin
          pos_nxt[k] = pos_r[k] + POS_W'(1);
          carry      = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (in_fire && emit) begin
      pos_r <= pos_nxt;
    end
  end

  // A held tick leaves the counters alone
  a_hold_keeps_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !emit) |=> $stable(pos_r))
    else $error("position moved on a held tick");

  // The final element wraps every counter to zero
  a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && res.valid && res.last) |=> (pos_r == '0))
    else $error("counters did not wrap after last element");

  // A consumed head is always an emitted element
  a_took_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && res.took) |=> (pos_r != $past(pos_r) || $past(res.last)))
    else $error("consumed head without advance");

endmodule

### rtl/tcp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_queue
// Short result queue that parts the front from the output channel and
// drives the output handshake from its head entry.
// ----------------------------------------------------------------------------
module tcp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tcp_pkg::tcp_res_t push_res,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output tcp_pkg::tcp_res_t head_res
);
  import tcp_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  tcp_res_t         mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full       = (count_r == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_res   = mem[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_res;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      case ({push, pop})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: ;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("pop did not drain queue");

  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("push did not fill queue");

endmodule

### rtl/tensor_constant_pad_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tensor_constant_pad_unit
// Streams a constant-padded copy of a tensor of up to MAX_AXES axes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one word per output tick, carrying
//   the head element of the source stream and a flag saying it is present.
//   Result channel (out_valid / out_stall): one result word per input word:
//   the element (head or pad word), an emitted flag, a consumed-head flag
//   and an end-of-tensor flag.
//   Config channel (cfg_valid / cfg_ready): index 0 input sizes, 1 pad
//   before, 2 pad after, 3 pad word; other indexes are dropped. Always ready.
//   Throughput is one word per cycle while the queue is not full; the
//   per-axis counters advance when an emitted word is accepted. A result
//   is held in a four-entry queue until the receiver takes it.
//   in_stall rises only while that queue is full, i.e. after the receiver
//   has held out_stall long enough to fill it.
//   Reset (rst_n low, synchronous) clears counters and queue, sets every
//   input axis size to one, pads and pad word to zero.
// ----------------------------------------------------------------------------
module tensor_constant_pad_unit #(
  parameter int  MAX_AXES  = tcp_pkg::DEF_MAX_AXES,
  parameter int  SIZE_BITS = tcp_pkg::DEF_SIZE_BITS,
  localparam int REG_W     = MAX_AXES * SIZE_BITS,
  localparam int CFG_W     = (REG_W > tcp_pkg::WORD_W) ? REG_W : tcp_pkg::WORD_W
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tcp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]              cfg_data,
  // input words
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tcp_pkg::WORD_W-1:0]    in_head_value,
  input  logic                          in_head_present,
  // result words
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tcp_pkg::WORD_W-1:0]    out_out_value,
  output logic                          out_out_valid,
  output logic                          out_took_head,
  output logic                          out_out_last
);
  import tcp_pkg::*;

  logic     in_fire;
  logic     out_fire;
  logic     q_full;
  tcp_res_t front_res;
  tcp_res_t head_res;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign in_fire   = in_valid && !q_full;
  assign out_fire  = out_valid && !out_stall;

  // Front: config, counters, classification
  tcp_front #(
    .MAX_AXES  (MAX_AXES),
    .SIZE_BITS (SIZE_BITS),
    .CFG_W     (CFG_W)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_fire      (in_fire),
    .head_value   (in_head_value),
    .head_present (in_head_present),
    .res          (front_res)
  );

  // Back: result queue and output channel
  tcp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_fire),
    .push_res   (front_res),
    .full       (q_full),
    .pop        (out_fire),
    .head_valid (out_valid),
    .head_res   (head_res)
  );

  assign out_out_value = head_res.value;
  assign out_out_valid = head_res.valid;
  assign out_took_head = head_res.took;
  assign out_out_last  = head_res.last;

endmodule
